>>> rtl/cps_pkg.sv
// Shared types and constants for the class pattern byte scanner.
package cps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int SIZE_BITS_DEF   = 24;

    localparam int SYMBOL_W  = 8;
    localparam int SYMBOLS   = 256;
    localparam int ROW_W     = 32;
    localparam int OFF_W     = 24;
    localparam int SO_W      = 16;
    localparam int MIN_W     = 24;
    localparam int PLEN_W    = 6;
    localparam int CFG_ADR_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_ADR_W-1:0] CFG_START_OFFSET   = 2'd0;
    localparam logic [CFG_ADR_W-1:0] CFG_MIN_SIZE       = 2'd1;
    localparam logic [CFG_ADR_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
    } t_byte_ctl;

    typedef struct packed {
        logic [OFF_W-1:0] next_offset;
        logic             matches_at_start;
    } t_result;

endpackage

>>> rtl/cps_class_mem.sv
// Class table memory: row loads and registered row lookup per data byte.
module cps_class_mem import cps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_kind,
    input  logic [SYMBOL_W-1:0] i_symbol,
    input  logic [ROW_W-1:0]    i_class_row,
    input  logic [SYMBOL_W-1:0] i_data_byte,
    input  logic                i_last,
    output t_byte_ctl           o_byte,
    output logic [ROW_W-1:0]    o_row
);

    logic [ROW_W-1:0] r_mem [SYMBOLS];
    logic [ROW_W-1:0] r_row;
    t_byte_ctl        r_byte;
    t_byte_ctl        n_byte;

    // Items arrive at most one per cycle, as i_accept allows, so a load always
    // commits before a later data byte reads the same row.
    always_ff @(posedge i_clk) begin
        if (i_accept && i_kind == KIND_LOAD) begin
            r_mem[i_symbol] <= i_class_row;
        end
        r_row <= r_mem[i_data_byte];
    end

    always_comb begin
        n_byte.valid = i_accept && i_kind == KIND_DATA;
        n_byte.last  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_row  = r_row;

endmodule

>>> rtl/cps_scan.sv
// Shift-and match state, hit tracking and end-of-buffer result.
module cps_scan import cps_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_byte_ctl         i_byte,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [SO_W-1:0]   i_start_offset,
    input  logic [MIN_W-1:0]  i_min_size,
    input  logic [PLEN_W-1:0] i_pattern_length,
    output logic              o_push,
    output t_result           o_result
);

    localparam int CMP_W   = (SIZE_BITS > MIN_W ? SIZE_BITS : MIN_W) + 2;
    localparam int LEN_W   = $clog2(PATTERN_MAX + 1) + 1;
    localparam int ROW_USE = PATTERN_MAX < ROW_W ? PATTERN_MAX : ROW_W;

    // derived from configuration, refreshed every cycle
    logic [PATTERN_MAX-1:0] r_mask;
    logic [PATTERN_MAX-1:0] r_top;
    logic [CMP_W-1:0]       r_lso_m1;
    logic [CMP_W-1:0]       r_need;
    logic [CMP_W-1:0]       r_need_m1;
    logic [PATTERN_MAX-1:0] n_mask;
    logic [PATTERN_MAX-1:0] n_top;
    logic [CMP_W-1:0]       n_lso_m1;
    logic [CMP_W-1:0]       n_need;
    logic [LEN_W-1:0]       w_len;
    logic [CMP_W-1:0]       w_span;

    // scan state
    logic [PATTERN_MAX-1:0] r_mv;
    logic [SIZE_BITS-1:0]   r_count;
    logic [SIZE_BITS-1:0]   r_first;
    logic                   r_found;
    logic                   r_start_hit;
    logic [PATTERN_MAX-1:0] n_mv;
    logic [SIZE_BITS-1:0]   n_count;
    logic [SIZE_BITS-1:0]   n_first;
    logic                   n_found;
    logic                   n_start_hit;

    logic [PATTERN_MAX-1:0] w_row;
    logic                   w_hit;
    logic [CMP_W-1:0]       w_pos;
    logic                   w_reach;
    logic                   w_at_start;
    logic [CMP_W-1:0]       w_k;
    logic                   w_sat;
    logic                   w_short;

    always_comb begin
        if (i_pattern_length == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(i_pattern_length) > PATTERN_MAX) begin
            w_len = LEN_W'(PATTERN_MAX);
        end else begin
            w_len = LEN_W'(i_pattern_length);
        end
        for (int p = 0; p < PATTERN_MAX; p++) begin
            n_mask[p] = LEN_W'(p) < w_len;
            n_top[p]  = LEN_W'(p + 1) == w_len;
        end
        w_span   = CMP_W'(i_start_offset) + CMP_W'(w_len);
        n_lso_m1 = w_span - CMP_W'(1);
        n_need   = (CMP_W'(i_min_size) > w_span) ? CMP_W'(i_min_size) : w_span;
    end

    always_ff @(posedge i_clk) begin
        r_mask    <= n_mask;
        r_top     <= n_top;
        r_lso_m1  <= n_lso_m1;
        r_need    <= n_need;
        r_need_m1 <= n_need - CMP_W'(1);
    end

    always_comb begin
        w_row      = PATTERN_MAX'(i_row[ROW_USE-1:0]);
        n_mv       = ((r_mv << 1) | PATTERN_MAX'(1)) & w_row & r_mask;
        w_hit      = |(n_mv & r_top);
        w_pos      = CMP_W'(r_count);
        w_reach    = w_pos >= r_lso_m1;
        w_at_start = w_pos == r_lso_m1;
        w_k        = w_pos - r_lso_m1;
        w_sat      = &r_count;
        n_count    = w_sat ? r_count : r_count + SIZE_BITS'(1);
        // size below need; compared against the pre-increment count
        w_short    = w_sat ? (w_pos < r_need) : (w_pos < r_need_m1);

        n_start_hit = r_start_hit;
        n_found     = r_found;
        n_first     = r_first;
        if (w_hit && w_reach) begin
            if (w_at_start) begin
                n_start_hit = 1'b1;
            end else if (!r_found) begin
                n_found = 1'b1;
                n_first = SIZE_BITS'(w_k);
            end
        end

        o_push = i_byte.valid && i_byte.last;
        o_result.matches_at_start = !w_short && n_start_hit;
        if (!w_short && n_found) begin
            o_result.next_offset = OFF_W'(n_first);
        end else begin
            o_result.next_offset = OFF_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv        <= '0;
            r_count     <= '0;
            r_first     <= '0;
            r_found     <= 1'b0;
            r_start_hit <= 1'b0;
        end else if (i_byte.valid) begin
            if (i_byte.last) begin
                r_mv        <= '0;
                r_count     <= '0;
                r_first     <= '0;
                r_found     <= 1'b0;
                r_start_hit <= 1'b0;
            end else begin
                r_mv        <= n_mv;
                r_count     <= n_count;
                r_first     <= n_first;
                r_found     <= n_found;
                r_start_hit <= n_start_hit;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.last) |=> (r_count == '0 && r_mv == '0 && !r_found))
        else $error("scan state not cleared after last byte");

    a_first_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_first != '0))
        else $error("recorded hit offset is zero");

endmodule

>>> rtl/cps_out_fifo.sv
// Four-entry result buffer between the scan stage and the output stream.
module cps_out_fifo import cps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    input  logic       i_ready,
    output logic       o_valid,
    output t_result    o_data,
    output logic [2:0] o_count
);

    t_result    r_slot [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = r_count != 3'd0;
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + 3'(i_push) - 3'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !w_pop && r_count == 3'd4))
        else $error("result buffer overflow");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push && r_count == 3'd1) |=> !o_valid)
        else $error("result buffer still valid after draining last entry");

endmodule

>>> rtl/class_pattern_byte_scanner.sv
// Class pattern byte scanner: top level with configuration registers.
// Usage:
//   Slave stream: tuser = kind (0 loads a class row, 1 delivers a data byte).
//   For a load, tdata carries symbol and class_row; for a data byte, tdata
//   carries data_byte and tlast marks the final byte of the buffer.
//   Master stream: one transfer per buffer, after its final byte, holding
//   matches_at_start and next_offset (first match offset >= 1, else size).
//   Configuration: write start_offset, min_size, pattern_length through
//   i_cfg_we/i_cfg_addr/i_cfg_wdata while no buffer is in flight.
// Timing:
//   One transfer per cycle on the slave side while tready is high. The class row is
//   read from a 256-entry synchronous memory at accept and the shift-and update
//   runs the cycle after, writing the result of the final byte into the result buffer.
//   The match vector loop is a single register stage, so a data byte can
//   follow every cycle while tready is high; loads write the memory at accept.
// Reset clears the scan state, the result buffer and the registers
// (pattern_length to 1); class rows stay undefined until loaded.
// When the receiver stalls, up to four results wait in a four-entry buffer;
// tready drops only once that buffer plus an in-flight final byte fill it.
module class_pattern_byte_scanner import cps_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [47:0]          i_s_axis_tdata,  // symbol, class_row, data_byte
    input  logic                 i_s_axis_tuser,  // kind
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [31:0]          o_m_axis_tdata,  // matches_at_start, next_offset, pad
    input  logic                 i_cfg_we,
    input  logic [CFG_ADR_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    logic [SO_W-1:0]   r_start_offset;
    logic [MIN_W-1:0]  r_min_size;
    logic [PLEN_W-1:0] r_pattern_length;

    logic              w_accept;
    t_byte_ctl         w_byte;
    logic [ROW_W-1:0]  w_row;
    logic              w_push;
    t_result           w_result;
    t_result           w_out;
    logic [2:0]        w_count;
    logic [2:0]        w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset   <= '0;
            r_min_size       <= '0;
            r_pattern_length <= PLEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_OFFSET:   r_start_offset   <= i_cfg_wdata[SO_W-1:0];
                CFG_MIN_SIZE:       r_min_size       <= i_cfg_wdata[MIN_W-1:0];
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_wdata[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // buffered results plus a final byte still in the scan stage
    assign w_load          = w_count + 3'(w_byte.valid && w_byte.last);
    assign o_s_axis_tready = w_load <= 3'd3;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    cps_class_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (i_s_axis_tuser),
        .i_symbol    (i_s_axis_tdata[7:0]),
        .i_class_row (i_s_axis_tdata[39:8]),
        .i_data_byte (i_s_axis_tdata[47:40]),
        .i_last      (i_s_axis_tlast),
        .o_byte      (w_byte),
        .o_row       (w_row)
    );

    cps_scan #(
        .PATTERN_MAX (PATTERN_MAX),
        .SIZE_BITS   (SIZE_BITS)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte           (w_byte),
        .i_row            (w_row),
        .i_start_offset   (r_start_offset),
        .i_min_size       (r_min_size),
        .i_pattern_length (r_pattern_length),
        .o_push           (w_push),
        .o_result         (w_result)
    );

    cps_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out),
        .o_count (w_count)
    );

    assign o_m_axis_tdata = {7'd0, w_out.next_offset, w_out.matches_at_start};

endmodule
